FILE: design/assert_macros.svh
// assertion helpers, clocked, reset-qualified
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SKRV_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// next-cycle implication
`define SKRV_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

FILE: design/skrv_pkg.sv
package skrv_pkg;

	function automatic int clog2_1(input int unsigned v);
		int r;
		r = $clog2(v);
		return (r < 1) ? 1 : r;
	endfunction

	localparam int MAX_ROWS_FIRST  = 64;
	localparam int MAX_ROWS_SECOND = 64;
	localparam int MAX_COLS_FIRST  = 32;
	localparam int MAX_COLS_SECOND = 32;

	localparam int K1_DEPTH   = MAX_ROWS_FIRST * MAX_COLS_FIRST;
	localparam int K2_DEPTH   = MAX_ROWS_SECOND * MAX_COLS_SECOND;
	localparam int SOL_DEPTH  = MAX_COLS_FIRST * MAX_COLS_SECOND;
	localparam int MEAS_DEPTH = MAX_ROWS_FIRST * MAX_ROWS_SECOND;
	localparam int PART_DEPTH = MAX_ROWS_FIRST * MAX_COLS_SECOND;

	localparam int K1_AW   = clog2_1(K1_DEPTH);
	localparam int K2_AW   = clog2_1(K2_DEPTH);
	localparam int SOL_AW  = clog2_1(SOL_DEPTH);
	localparam int MEAS_AW = clog2_1(MEAS_DEPTH);
	localparam int PART_AW = clog2_1(PART_DEPTH);

	localparam int RF_W = clog2_1(MAX_ROWS_FIRST);
	localparam int RS_W = clog2_1(MAX_ROWS_SECOND);
	localparam int CF_W = clog2_1(MAX_COLS_FIRST);
	localparam int CS_W = clog2_1(MAX_COLS_SECOND);

	localparam int M1_W = clog2_1(MAX_ROWS_FIRST + 1);
	localparam int M2_W = clog2_1(MAX_ROWS_SECOND + 1);
	localparam int N1_W = clog2_1(MAX_COLS_FIRST + 1);
	localparam int N2_W = clog2_1(MAX_COLS_SECOND + 1);

	localparam int CNT_W = clog2_1(MAX_ROWS_FIRST * MAX_ROWS_SECOND + 1);

	localparam int DATA_W = 32;
	localparam int MS_W   = 48;
	localparam int IT_W   = clog2_1(MS_W + 1);

	localparam logic [2:0] REQ_K1    = 3'd0;
	localparam logic [2:0] REQ_K2    = 3'd1;
	localparam logic [2:0] REQ_SOL   = 3'd2;
	localparam logic [2:0] REQ_MEAS  = 3'd3;
	localparam logic [2:0] REQ_START = 3'd4;

	localparam logic [2:0] CFG_MODE = 3'd0;
	localparam logic [2:0] CFG_RF   = 3'd1;
	localparam logic [2:0] CFG_RS   = 3'd2;
	localparam logic [2:0] CFG_CF   = 3'd3;
	localparam logic [2:0] CFG_CS   = 3'd4;

	localparam logic [1:0] MODE_VEC = 2'd1;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_RD    = 9'b000000010,
		S_MUL   = 9'b000000100,
		S_ACC   = 9'b000001000,
		S_FIN   = 9'b000010000,
		S_SQ    = 9'b000100000,
		S_SQACC = 9'b001000000,
		S_DST   = 9'b010000000,
		S_DIV   = 9'b100000000
	} state_t;

	typedef enum logic [2:0] {
		PH_VEC = 3'b001,
		PH_P1  = 3'b010,
		PH_P2  = 3'b100
	} phase_t;

	typedef struct packed {
		logic               sat;
		logic signed [63:0] val;
	} sat64_t;

	typedef struct packed {
		logic               sat;
		logic signed [31:0] val;
	} rnd_t;

	function automatic sat64_t sat_add(input logic signed [63:0] a,
			input logic signed [63:0] b);
		sat64_t r;
		logic signed [63:0] s;
		s = a + b;
		r.sat = (a[63] == b[63]) && (s[63] != a[63]);
		if (r.sat) begin
			r.val = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		end else begin
			r.val = s;
		end
		return r;
	endfunction

	function automatic rnd_t round_q16(input logic signed [63:0] a);
		rnd_t r;
		logic signed [63:0] t;
		t = a + 64'sd32768;
		r.sat = 1'b0;
		if (a >= 64'sh0000_7FFF_FFFF_8000) begin
			r.sat = 1'b1;
			r.val = {1'b0, {31{1'b1}}};
		end else if (a < 64'shFFFF_7FFF_FFFF_8000) begin
			r.sat = 1'b1;
			r.val = {1'b1, 31'd0};
		end else begin
			r.val = t[47:16];
		end
		return r;
	endfunction

	function automatic logic [8:0] clamp_dim(input logic [6:0] v, input int unsigned mx);
		logic [8:0] r;
		if (v == 7'd0) begin
			r = 9'd1;
		end else if (32'(v) > mx) begin
			r = 9'(mx);
		end else begin
			r = 9'(v);
		end
		return r;
	endfunction

endpackage

FILE: design/skrv_ram.sv
module skrv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: design/skrv_div.sv
module skrv_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [63:0]               dividend,
	input  logic [skrv_pkg::CNT_W-1:0] divisor,
	output logic                      done,
	output logic [skrv_pkg::MS_W-1:0] quotient
);

	logic                             busy_q;
	logic                             done_q;
	logic [skrv_pkg::IT_W-1:0]        it_q;
	logic [skrv_pkg::MS_W-1:0]        dvd_q;
	logic [skrv_pkg::CNT_W-1:0]       rem_q;
	logic [skrv_pkg::CNT_W:0]         trial;
	logic                             ge;
	logic [skrv_pkg::CNT_W:0]         diff;

	assign trial = {rem_q, dvd_q[skrv_pkg::MS_W-1]};
	assign ge    = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			it_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				it_q   <= skrv_pkg::IT_W'(skrv_pkg::MS_W);
			end else if (busy_q) begin
				it_q <= it_q - 1'b1;
				if (it_q == skrv_pkg::IT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend[63:16];
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[skrv_pkg::MS_W-2:0], ge};
			rem_q <= ge ? diff[skrv_pkg::CNT_W-1:0] : trial[skrv_pkg::CNT_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

FILE: design/separable_kernel_residual_variance_top.sv
// Load words (kernel one, kernel two, solution, measured): one per cycle while not stalled, no result.
// Start word, vector mode: per row, n1 products (read, multiply, accumulate), then round,
//   square and add; 2-D mode: m1*n2 first-pass sums of n1 products, then m1*m2
//   second-pass sums of n2 products, each rounded, squared and added; the tail is the divider.
// Input stalls while a start runs; a start also stalls while the last result waits.
// Reset clears control and configuration (2,64,64,32,32); stores are not cleared.
module separable_kernel_residual_variance_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  req_type,
	input  logic [11:0] index,
	input  logic signed [31:0] value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [47:0] mean_square,
	output logic        saturated,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [6:0]  cfg_data
);

	skrv_pkg::state_t state_q;
	skrv_pkg::phase_t phase_q;

	logic [1:0] mode_q;
	logic [6:0] rows_first_q;
	logic [6:0] rows_second_q;
	logic [5:0] cols_first_q;
	logic [5:0] cols_second_q;

	logic [skrv_pkg::M1_W-1:0] m1_q;
	logic [skrv_pkg::M2_W-1:0] m2_q;
	logic [skrv_pkg::N1_W-1:0] n1_q;
	logic [skrv_pkg::N2_W-1:0] n2_q;
	logic [skrv_pkg::M1_W-1:0] m1c;
	logic [skrv_pkg::M2_W-1:0] m2c;
	logic [skrv_pkg::N1_W-1:0] n1c;
	logic [skrv_pkg::N2_W-1:0] n2c;
	logic [skrv_pkg::CNT_W-1:0] count_q;

	logic [skrv_pkg::RF_W-1:0] r_q;
	logic [skrv_pkg::RS_W-1:0] s_q;
	logic [skrv_pkg::CF_W-1:0] k_q;
	logic [skrv_pkg::CS_W-1:0] c_q;

	logic signed [63:0] acc_q;
	logic signed [63:0] prod_q;
	logic signed [31:0] rnd_q;
	logic [63:0]        sq_q;
	logic [63:0]        sqacc_q;
	logic               sat_q;

	logic               out_valid_q;
	logic [47:0]        mean_square_q;
	logic               saturated_q;

	logic in_acc;
	logic start_acc;
	logic r_last, s_last, k_last, c_last, inner_last;

	logic [skrv_pkg::K1_AW-1:0]   k1_raddr;
	logic [skrv_pkg::K2_AW-1:0]   k2_raddr;
	logic [skrv_pkg::SOL_AW-1:0]  sol_raddr;
	logic [skrv_pkg::MEAS_AW-1:0] meas_raddr;
	logic [skrv_pkg::PART_AW-1:0] part_addr;
	logic [31:0] k1_rdata, k2_rdata, sol_rdata, meas_rdata, part_rdata;
	logic k1_we, k2_we, sol_we, meas_we, part_we;
	logic [31:0] opa, opb;

	skrv_pkg::sat64_t acc_nx;
	skrv_pkg::rnd_t   rnd_nx;
	logic signed [32:0] diff;
	logic [31:0]        absd;
	logic [64:0]        sqsum;

	logic        div_start;
	logic        div_done;
	logic [47:0] div_q;

	assign in_stall  = (state_q != skrv_pkg::S_IDLE) ||
		(out_valid_q && (req_type == skrv_pkg::REQ_START));
	assign in_acc    = in_valid && !in_stall;
	assign start_acc = in_acc && (req_type == skrv_pkg::REQ_START);
	assign cfg_ready = 1'b1;

	assign m1c = skrv_pkg::M1_W'(skrv_pkg::clamp_dim(rows_first_q, skrv_pkg::MAX_ROWS_FIRST));
	assign m2c = skrv_pkg::M2_W'(skrv_pkg::clamp_dim(rows_second_q, skrv_pkg::MAX_ROWS_SECOND));
	assign n1c = skrv_pkg::N1_W'(skrv_pkg::clamp_dim(7'(cols_first_q), skrv_pkg::MAX_COLS_FIRST));
	assign n2c = skrv_pkg::N2_W'(skrv_pkg::clamp_dim(7'(cols_second_q),
		skrv_pkg::MAX_COLS_SECOND));

	assign r_last = r_q == skrv_pkg::RF_W'(m1_q - 1'b1);
	assign s_last = s_q == skrv_pkg::RS_W'(m2_q - 1'b1);
	assign k_last = k_q == skrv_pkg::CF_W'(n1_q - 1'b1);
	assign c_last = c_q == skrv_pkg::CS_W'(n2_q - 1'b1);
	assign inner_last = (phase_q == skrv_pkg::PH_P2) ? c_last : k_last;

	assign k1_raddr = skrv_pkg::K1_AW'(skrv_pkg::K1_AW'(k_q) * skrv_pkg::K1_AW'(m1_q)
		+ skrv_pkg::K1_AW'(r_q));
	assign sol_raddr = (phase_q == skrv_pkg::PH_VEC) ? skrv_pkg::SOL_AW'(k_q) :
		skrv_pkg::SOL_AW'(skrv_pkg::SOL_AW'(k_q) * skrv_pkg::SOL_AW'(n2_q)
		+ skrv_pkg::SOL_AW'(c_q));
	assign part_addr = skrv_pkg::PART_AW'(skrv_pkg::PART_AW'(c_q) * skrv_pkg::PART_AW'(m1_q)
		+ skrv_pkg::PART_AW'(r_q));
	assign k2_raddr = skrv_pkg::K2_AW'(skrv_pkg::K2_AW'(c_q) * skrv_pkg::K2_AW'(m2_q)
		+ skrv_pkg::K2_AW'(s_q));
	assign meas_raddr = skrv_pkg::MEAS_AW'(skrv_pkg::MEAS_AW'(s_q) * skrv_pkg::MEAS_AW'(m1_q)
		+ skrv_pkg::MEAS_AW'(r_q));

	assign k1_we   = in_acc && (req_type == skrv_pkg::REQ_K1) && (index < skrv_pkg::K1_DEPTH);
	assign k2_we   = in_acc && (req_type == skrv_pkg::REQ_K2) && (index < skrv_pkg::K2_DEPTH);
	assign sol_we  = in_acc && (req_type == skrv_pkg::REQ_SOL) &&
		(index < skrv_pkg::SOL_DEPTH);
	assign meas_we = in_acc && (req_type == skrv_pkg::REQ_MEAS) &&
		(index < skrv_pkg::MEAS_DEPTH);
	assign part_we = (state_q == skrv_pkg::S_FIN) && (phase_q == skrv_pkg::PH_P1);

	skrv_ram #(.WIDTH(32), .DEPTH(skrv_pkg::K1_DEPTH)) u_k1 (
		.clk(clk), .we(k1_we), .waddr(index[skrv_pkg::K1_AW-1:0]), .wdata(value),
		.raddr(k1_raddr), .rdata(k1_rdata));
	skrv_ram #(.WIDTH(32), .DEPTH(skrv_pkg::K2_DEPTH)) u_k2 (
		.clk(clk), .we(k2_we), .waddr(index[skrv_pkg::K2_AW-1:0]), .wdata(value),
		.raddr(k2_raddr), .rdata(k2_rdata));
	skrv_ram #(.WIDTH(32), .DEPTH(skrv_pkg::SOL_DEPTH)) u_sol (
		.clk(clk), .we(sol_we), .waddr(index[skrv_pkg::SOL_AW-1:0]), .wdata(value),
		.raddr(sol_raddr), .rdata(sol_rdata));
	skrv_ram #(.WIDTH(32), .DEPTH(skrv_pkg::MEAS_DEPTH)) u_meas (
		.clk(clk), .we(meas_we), .waddr(index[skrv_pkg::MEAS_AW-1:0]), .wdata(value),
		.raddr(meas_raddr), .rdata(meas_rdata));
	skrv_ram #(.WIDTH(32), .DEPTH(skrv_pkg::PART_DEPTH)) u_part (
		.clk(clk), .we(part_we), .waddr(part_addr), .wdata(rnd_nx.val),
		.raddr(part_addr), .rdata(part_rdata));

	assign opa = (phase_q == skrv_pkg::PH_P2) ? part_rdata : k1_rdata;
	assign opb = (phase_q == skrv_pkg::PH_P2) ? k2_rdata : sol_rdata;

	assign acc_nx = skrv_pkg::sat_add(acc_q, prod_q);
	assign rnd_nx = skrv_pkg::round_q16(acc_q);
	assign diff   = {rnd_q[31], rnd_q} - {meas_rdata[31], meas_rdata};
	assign absd   = diff[32] ? 32'(-diff) : diff[31:0];
	assign sqsum  = {1'b0, sqacc_q} + {1'b0, sq_q};

	assign div_start = state_q == skrv_pkg::S_DST;

	skrv_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(sqacc_q),
		.divisor(count_q), .done(div_done), .quotient(div_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= 2'd2;
			rows_first_q  <= 7'd64;
			rows_second_q <= 7'd64;
			cols_first_q  <= 6'd32;
			cols_second_q <= 6'd32;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				skrv_pkg::CFG_MODE: mode_q        <= cfg_data[1:0];
				skrv_pkg::CFG_RF:   rows_first_q  <= cfg_data;
				skrv_pkg::CFG_RS:   rows_second_q <= cfg_data;
				skrv_pkg::CFG_CF:   cols_first_q  <= cfg_data[5:0];
				skrv_pkg::CFG_CS:   cols_second_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= skrv_pkg::S_IDLE;
			phase_q     <= skrv_pkg::PH_P1;
			out_valid_q <= 1'b0;
			sat_q       <= 1'b0;
			r_q         <= '0;
			s_q         <= '0;
			k_q         <= '0;
			c_q         <= '0;
			sqacc_q     <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				skrv_pkg::S_IDLE: begin
					if (start_acc) begin
						phase_q <= (mode_q == skrv_pkg::MODE_VEC) ? skrv_pkg::PH_VEC :
							skrv_pkg::PH_P1;
						r_q     <= '0;
						s_q     <= '0;
						k_q     <= '0;
						c_q     <= '0;
						sat_q   <= 1'b0;
						sqacc_q <= '0;
						state_q <= skrv_pkg::S_RD;
					end
				end
				skrv_pkg::S_RD: state_q <= skrv_pkg::S_MUL;
				skrv_pkg::S_MUL: state_q <= skrv_pkg::S_ACC;
				skrv_pkg::S_ACC: begin
					if (acc_nx.sat) begin
						sat_q <= 1'b1;
					end
					if (inner_last) begin
						state_q <= skrv_pkg::S_FIN;
					end else begin
						if (phase_q == skrv_pkg::PH_P2) begin
							c_q <= c_q + 1'b1;
						end else begin
							k_q <= k_q + 1'b1;
						end
						state_q <= skrv_pkg::S_RD;
					end
				end
				skrv_pkg::S_FIN: begin
					if (rnd_nx.sat) begin
						sat_q <= 1'b1;
					end
					if (phase_q == skrv_pkg::PH_P1) begin
						k_q     <= '0;
						state_q <= skrv_pkg::S_RD;
						if (c_last) begin
							c_q <= '0;
							if (r_last) begin
								r_q     <= '0;
								phase_q <= skrv_pkg::PH_P2;
							end else begin
								r_q <= r_q + 1'b1;
							end
						end else begin
							c_q <= c_q + 1'b1;
						end
					end else begin
						state_q <= skrv_pkg::S_SQ;
					end
				end
				skrv_pkg::S_SQ: state_q <= skrv_pkg::S_SQACC;
				skrv_pkg::S_SQACC: begin
					if (sqsum[64]) begin
						sqacc_q <= '1;
						sat_q   <= 1'b1;
					end else begin
						sqacc_q <= sqsum[63:0];
					end
					k_q <= '0;
					c_q <= '0;
					if (r_last) begin
						r_q <= '0;
						if ((phase_q == skrv_pkg::PH_VEC) || s_last) begin
							state_q <= skrv_pkg::S_DST;
						end else begin
							s_q     <= s_q + 1'b1;
							state_q <= skrv_pkg::S_RD;
						end
					end else begin
						r_q     <= r_q + 1'b1;
						state_q <= skrv_pkg::S_RD;
					end
				end
				skrv_pkg::S_DST: state_q <= skrv_pkg::S_DIV;
				skrv_pkg::S_DIV: begin
					if (div_done) begin
						out_valid_q <= 1'b1;
						state_q     <= skrv_pkg::S_IDLE;
					end
				end
				default: state_q <= skrv_pkg::S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start_acc) begin
			m1_q    <= m1c;
			m2_q    <= m2c;
			n1_q    <= n1c;
			n2_q    <= n2c;
			count_q <= (mode_q == skrv_pkg::MODE_VEC) ? skrv_pkg::CNT_W'(m1c) :
				skrv_pkg::CNT_W'(skrv_pkg::CNT_W'(m1c) * skrv_pkg::CNT_W'(m2c));
			acc_q   <= '0;
		end
		if (state_q == skrv_pkg::S_MUL) begin
			prod_q <= $signed(opa) * $signed(opb);
		end
		if (state_q == skrv_pkg::S_ACC) begin
			acc_q <= acc_nx.val;
		end
		if (state_q == skrv_pkg::S_FIN) begin
			rnd_q <= rnd_nx.val;
			if (phase_q == skrv_pkg::PH_P1) begin
				acc_q <= '0;
			end
		end
		if (state_q == skrv_pkg::S_SQ) begin
			sq_q <= absd * absd;
		end
		if (state_q == skrv_pkg::S_SQACC) begin
			acc_q <= '0;
		end
		if ((state_q == skrv_pkg::S_DIV) && div_done) begin
			mean_square_q <= div_q;
			saturated_q   <= sat_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign mean_square = mean_square_q;
	assign saturated   = saturated_q;

endmodule

FILE: design/skrv_chk.sv
`include "assert_macros.svh"

module skrv_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [2:0]  req_type,
	input logic        out_valid,
	input logic        out_stall,
	input logic [47:0] mean_square,
	input logic        saturated
);

	`SKRV_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
	`SKRV_ASSERT_NXT(a_out_stable, clk, arst_n, out_valid && out_stall,
		$stable(mean_square) && $stable(saturated))
	`SKRV_ASSERT_NXT(a_start_quiet, clk, arst_n,
		in_valid && !in_stall && (req_type == skrv_pkg::REQ_START), !out_valid)
	`SKRV_ASSERT_IMP(a_rise_busy, clk, arst_n, $rose(out_valid), $past(in_stall))

endmodule

bind separable_kernel_residual_variance_top skrv_chk u_skrv_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.req_type(req_type), .out_valid(out_valid), .out_stall(out_stall),
	.mean_square(mean_square), .saturated(saturated));

FILE: test/separable_kernel_residual_variance_top_tb.sv
module separable_kernel_residual_variance_top_tb;

	typedef struct {
		logic [47:0] mean_sq;
		logic        sat;
	} mean_result_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [2:0]         req_type;
	logic [11:0]        index;
	logic signed [31:0] value;
	logic               out_valid;
	logic               out_stall;
	logic [47:0]        mean_square;
	logic               saturated;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [2:0]         cfg_index;
	logic [6:0]         cfg_data;

	logic signed [31:0] kone_mem [skrv_pkg::K1_DEPTH];
	logic signed [31:0] ktwo_mem [skrv_pkg::K2_DEPTH];
	logic signed [31:0] sol_mem  [skrv_pkg::SOL_DEPTH];
	logic signed [31:0] meas_mem [skrv_pkg::MEAS_DEPTH];
	longint             part_mem [skrv_pkg::PART_DEPTH];
	logic [1:0]         mode_reg;
	logic [6:0]         rf_reg, rs_reg;
	logic [5:0]         cf_reg, cs_reg;

	mean_result_t pending_means[$];
	int           mismatches;
	bit           fit_sat;
	bit           in_burst;
	bit           out_burst;

	separable_kernel_residual_variance_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .index(index), .value(value),
		.out_valid(out_valid), .out_stall(out_stall),
		.mean_square(mean_square), .saturated(saturated),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic int dim_of(input int v, input int mx);
		if (v == 0) begin
			return 1;
		end
		return (v > mx) ? mx : v;
	endfunction

	function automatic longint add_sat(input longint a, input longint b);
		longint s;
		s = a + b;
		if ((a[63] == b[63]) && (s[63] != a[63])) begin
			fit_sat = 1'b1;
			return a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		end
		return s;
	endfunction

	function automatic longint to_q16(input longint a);
		longint lim;
		lim = 64'sd1 <<< 47;
		if (a >= lim - 32768) begin
			fit_sat = 1'b1;
			return 64'sd2147483647;
		end
		if (a < -lim - 32768) begin
			fit_sat = 1'b1;
			return -64'sd2147483648;
		end
		return (a + 32768) >>> 16;
	endfunction

	function automatic void add_residual(inout logic [63:0] sq_acc, input longint model,
			input longint meas);
		longint d;
		logic [63:0] ud, sq;
		d = model - meas;
		ud = (d < 0) ? -d : d;
		sq = ud * ud;
		if (sq_acc > 64'hFFFF_FFFF_FFFF_FFFF - sq) begin
			sq_acc = 64'hFFFF_FFFF_FFFF_FFFF;
			fit_sat = 1'b1;
		end else begin
			sq_acc = sq_acc + sq;
		end
	endfunction

	function automatic mean_result_t residual_mean();
		mean_result_t res;
		int m1, m2, n1, n2, count;
		longint acc;
		logic [63:0] sq_acc, divisor;
		m1 = dim_of(rf_reg, skrv_pkg::MAX_ROWS_FIRST);
		m2 = dim_of(rs_reg, skrv_pkg::MAX_ROWS_SECOND);
		n1 = dim_of(cf_reg, skrv_pkg::MAX_COLS_FIRST);
		n2 = dim_of(cs_reg, skrv_pkg::MAX_COLS_SECOND);
		fit_sat = 1'b0;
		sq_acc = '0;
		if (mode_reg == skrv_pkg::MODE_VEC) begin
			for (int r = 0; r < m1; r++) begin
				acc = 0;
				for (int k = 0; k < n1; k++)
					acc = add_sat(acc, longint'(kone_mem[r + k * m1]) * longint'(sol_mem[k]));
				add_residual(sq_acc, to_q16(acc), meas_mem[r]);
			end
			count = m1;
		end else begin
			for (int r = 0; r < m1; r++)
				for (int c = 0; c < n2; c++) begin
					acc = 0;
					for (int k = 0; k < n1; k++)
						acc = add_sat(acc, longint'(kone_mem[r + k * m1]) *
							longint'(sol_mem[k * n2 + c]));
					part_mem[r + c * m1] = to_q16(acc);
				end
			for (int s = 0; s < m2; s++)
				for (int r = 0; r < m1; r++) begin
					acc = 0;
					for (int c = 0; c < n2; c++)
						acc = add_sat(acc, part_mem[r + c * m1] *
							longint'(ktwo_mem[s + c * m2]));
					add_residual(sq_acc, to_q16(acc), meas_mem[r + s * m1]);
				end
			count = m1 * m2;
		end
		divisor = 64'(count) << 16;
		sq_acc = sq_acc / divisor;
		res.mean_sq = sq_acc[47:0];
		res.sat = fit_sat;
		return res;
	endfunction

	function automatic void apply_word(input logic [2:0] t, input int i,
			input logic signed [31:0] v);
		case (t)
			skrv_pkg::REQ_K1: begin
				if (i < skrv_pkg::K1_DEPTH) kone_mem[i] = v;
			end
			skrv_pkg::REQ_K2: begin
				if (i < skrv_pkg::K2_DEPTH) ktwo_mem[i] = v;
			end
			skrv_pkg::REQ_SOL: begin
				if (i < skrv_pkg::SOL_DEPTH) sol_mem[i] = v;
			end
			skrv_pkg::REQ_MEAS: begin
				if (i < skrv_pkg::MEAS_DEPTH) meas_mem[i] = v;
			end
			skrv_pkg::REQ_START: begin
				pending_means.push_back(residual_mean());
			end
			default: begin
			end
		endcase
	endfunction

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2, 3: return $urandom;
			default: return int'($urandom_range(0, 262143)) - 131072;
		endcase
	endfunction

	task automatic send_word(input logic [2:0] t, input logic [11:0] i,
			input logic signed [31:0] v);
		int gap;
		gap = in_burst ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= t;
		index <= i;
		value <= v;
		do @(posedge clk); while (in_stall);
		apply_word(t, i, v);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_means.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic configure(input logic [6:0] mode, input logic [6:0] rf, input logic [6:0] rs,
			input logic [6:0] cf, input logic [6:0] cs);
		logic [6:0] vals [5];
		vals = '{mode, rf, rs, cf, cs};
		drain();
		for (int r = 0; r < 5; r++) begin
			cfg_valid <= 1'b1;
			cfg_index <= 3'(r);
			cfg_data <= vals[r];
			do @(posedge clk); while (!cfg_ready);
			case (3'(r))
				skrv_pkg::CFG_MODE: mode_reg = vals[r][1:0];
				skrv_pkg::CFG_RF: rf_reg = vals[r];
				skrv_pkg::CFG_RS: rs_reg = vals[r];
				skrv_pkg::CFG_CF: cf_reg = vals[r][5:0];
				skrv_pkg::CFG_CS: cs_reg = vals[r][5:0];
				default: begin
				end
			endcase
		end
		cfg_valid <= 1'b1;
		cfg_index <= 3'($urandom_range(5, 7));
		cfg_data <= 7'($urandom);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic noise_word();
		if ($urandom_range(0, 3) == 0) begin
			send_word(3'($urandom_range(5, 7)), 12'($urandom), $urandom);
		end else begin
			send_word(3'($urandom_range(0, 3)), 12'($urandom), pick_value());
		end
	endtask

	task automatic load_store(input logic [2:0] t, input int n, input int fixed_sel);
		for (int i = 0; i < n; i++) begin
			if (fixed_sel == 1) begin
				send_word(t, 12'(i), 32'sh7FFF_FFFF);
			end else if (fixed_sel == 2) begin
				send_word(t, 12'(i), 32'sh8000_0000);
			end else begin
				send_word(t, 12'(i), pick_value());
			end
		end
	endtask

	task automatic fill_and_start(input int fixed_sel, input int noise_pct);
		int m1, m2, n1, n2;
		m1 = dim_of(rf_reg, skrv_pkg::MAX_ROWS_FIRST);
		m2 = dim_of(rs_reg, skrv_pkg::MAX_ROWS_SECOND);
		n1 = dim_of(cf_reg, skrv_pkg::MAX_COLS_FIRST);
		n2 = dim_of(cs_reg, skrv_pkg::MAX_COLS_SECOND);
		if ($urandom_range(0, 99) < noise_pct) noise_word();
		load_store(skrv_pkg::REQ_K1, m1 * n1, fixed_sel);
		if (mode_reg == skrv_pkg::MODE_VEC) begin
			load_store(skrv_pkg::REQ_SOL, n1, fixed_sel);
			load_store(skrv_pkg::REQ_MEAS, m1, 0);
		end else begin
			load_store(skrv_pkg::REQ_SOL, n1 * n2, fixed_sel);
			load_store(skrv_pkg::REQ_K2, m2 * n2, fixed_sel);
			if ($urandom_range(0, 99) < noise_pct) noise_word();
			load_store(skrv_pkg::REQ_MEAS, m1 * m2, 0);
		end
		if ($urandom_range(0, 99) < noise_pct) noise_word();
		send_word(skrv_pkg::REQ_START, 12'($urandom), $urandom);
	endtask

	task automatic test_vector_directed();
		configure(7'd1, 7'd3, 7'd1, 7'd2, 7'd1);
		fill_and_start(0, 0);
		send_word(skrv_pkg::REQ_K1, 12'd4095, 32'sh7FFF_FFFF);
		send_word(skrv_pkg::REQ_SOL, 12'd2048, 32'sh8000_0000);
		send_word(3'd5, 12'd0, 32'sh1234_5678);
		send_word(3'd6, 12'd4095, 32'sh8000_0000);
		send_word(3'd7, 12'd1, 32'sh7FFF_FFFF);
		send_word(skrv_pkg::REQ_MEAS, 12'd4095, 32'sh0001_0000);
		send_word(skrv_pkg::REQ_START, 12'hFFF, 32'shFFFF_FFFF);
		configure(7'd125, 7'd0, 7'd0, 7'd0, 7'd0);
		fill_and_start(0, 0);
	endtask

	task automatic test_two_dim_directed();
		configure(7'd2, 7'd2, 7'd3, 7'd2, 7'd2);
		fill_and_start(0, 0);
		configure(7'd0, 7'd1, 7'd2, 7'd1, 7'd2);
		fill_and_start(0, 0);
		configure(7'd3, 7'd2, 7'd1, 7'd1, 7'd1);
		fill_and_start(0, 0);
	endtask

	task automatic test_saturation();
		configure(7'd1, 7'd1, 7'd1, 7'd32, 7'd1);
		fill_and_start(1, 0);
		fill_and_start(2, 0);
		configure(7'd2, 7'd2, 7'd2, 7'd2, 7'd2);
		fill_and_start(1, 0);
		fill_and_start(2, 0);
	endtask

	task automatic test_dimension_limits();
		in_burst = 1'b1;
		configure(7'd2, 7'd127, 7'd1, 7'd1, 7'd1);
		fill_and_start(0, 0);
		configure(7'd2, 7'd1, 7'd127, 7'd1, 7'd1);
		fill_and_start(0, 0);
		configure(7'd1, 7'd1, 7'd1, 7'd63, 7'd1);
		fill_and_start(0, 0);
		configure(7'd2, 7'd1, 7'd1, 7'd1, 7'd63);
		fill_and_start(0, 0);
		in_burst = 1'b0;
	endtask

	task automatic test_random_sets();
		logic [6:0] mode;
		for (int set_no = 0; set_no < 45; set_no++) begin
			in_burst = ($urandom_range(0, 3) == 0);
			mode = ($urandom_range(0, 5) == 0) ? 7'($urandom) : 7'($urandom_range(1, 2));
			configure(mode, 7'($urandom_range(0, 4)), 7'($urandom_range(0, 4)),
				7'($urandom_range(0, 4)), 7'($urandom_range(0, 4)));
			fill_and_start(0, 30);
			repeat ($urandom_range(0, 3)) begin
				send_word(skrv_pkg::REQ_MEAS, 12'($urandom_range(0, 3)), pick_value());
				send_word(skrv_pkg::REQ_START, 12'($urandom), $urandom);
			end
		end
		in_burst = 1'b0;
	endtask

	initial begin
		out_stall <= 1'b0;
		out_burst = 1'b0;
		@(posedge arst_n);
		forever begin
			int hold;
			if ($urandom_range(0, 7) == 0) out_burst = ~out_burst;
			hold = out_burst ? 0 : $urandom_range(0, 6);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	always @(posedge clk) begin : check_results
		mean_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_means.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: mean_square %0h saturated %0b",
						mean_square, saturated);
			end else begin
				want = pending_means.pop_front();
				if (mean_square !== want.mean_sq || saturated !== want.sat) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: mean_square exp %0h got %0h, saturated exp %0b got %0b",
							want.mean_sq, mean_square, want.sat, saturated);
				end
			end
		end
	end

	initial begin
		#40000000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		mismatches = 0;
		in_burst = 1'b0;
		mode_reg = 2'd2;
		rf_reg = 7'd64;
		rs_reg = 7'd64;
		cf_reg = 6'd32;
		cs_reg = 6'd32;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		req_type <= skrv_pkg::REQ_K1;
		index <= '0;
		value <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= skrv_pkg::CFG_MODE;
		cfg_data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_vector_directed();
		test_two_dim_directed();
		test_saturation();
		test_dimension_limits();
		test_random_sets();
		drain();
		repeat (60) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
